@@ hw/rtl/reverse_in_groups_core_macros.svh @@
// assertion macros used by the reverse_in_groups_core datapath
`ifndef REVERSE_IN_GROUPS_CORE_MACROS_SVH
`define REVERSE_IN_GROUPS_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define RIG_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define RIG_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/rig_pkg.sv @@
// shared constants and controller/datapath interface types
`default_nettype none

package rig_pkg;

   localparam int RIG_MAX_GROUP  = 16;
   localparam int RIG_DATA_WIDTH = 32;
   localparam int RIG_CSR_WIDTH  = 5;

   // controller to datapath
   typedef struct packed {
      logic write;   // store the accepted value
      logic start;   // close the group and set up the drain
      logic rd;      // read one buffered value into the output register
   } rig_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic group_full;  // the incoming value completes a group
      logic last_read;   // one value left to drain
      logic out_free;    // output register can take a value this cycle
   } rig_sts_type;

endpackage

`default_nettype wire

@@ hw/rtl/rig_ctrl.sv @@
// control state machine: fill the group buffer, then drain it
`default_nettype none

module rig_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire                  req_end_of_list,
   input  rig_pkg::rig_sts_type sts,
   output rig_pkg::rig_cmd_type cmd
);
   import rig_pkg::*;

   localparam logic ST_FILL  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   assign req_ready = (state_ff == ST_FILL);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      cmd.write = 1'b0;
      cmd.start = 1'b0;
      cmd.rd    = 1'b0;
      unique case (state_ff)
         ST_FILL: begin
            cmd.write = accept;
            if (accept && (sts.group_full || req_end_of_list)) begin
               cmd.start = 1'b1;
               state_in  = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.rd = sts.out_free;
            if (sts.out_free && sts.last_read) begin
               state_in = ST_FILL;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/rig_datapath.sv @@
// group buffer, fill and drain counters, group size register, output register
`default_nettype none

`include "reverse_in_groups_core_macros.svh"

module rig_datapath #(
   parameter int MAX_GROUP  = rig_pkg::RIG_MAX_GROUP,
   parameter int DATA_WIDTH = rig_pkg::RIG_DATA_WIDTH
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire signed [DATA_WIDTH-1:0]         req_value,
   input  wire                                 req_end_of_list,
   input  wire                                 csr_valid,
   input  wire [rig_pkg::RIG_CSR_WIDTH-1:0]    csr_group_size,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic signed [DATA_WIDTH-1:0]        rsp_out_value,
   output logic                                rsp_out_last,
   input  rig_pkg::rig_cmd_type                cmd,
   output rig_pkg::rig_sts_type                sts
);
   import rig_pkg::*;

   localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int CW = $clog2(MAX_GROUP + 1);
   localparam int KW = (CW > RIG_CSR_WIDTH) ? CW : RIG_CSR_WIDTH;

   logic [DATA_WIDTH-1:0]        mem [MAX_GROUP];
   logic [RIG_CSR_WIDTH-1:0]     group_size_ff;
   logic [CW-1:0]                fill_ff;
   logic [CW-1:0]                fill_in;
   logic [CW-1:0]                rem_ff;
   logic [CW-1:0]                rem_in;
   logic [AW-1:0]                addr_ff;
   logic [AW-1:0]                addr_in;
   logic                         rev_ff;
   logic                         eol_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_last_ff;
   logic signed [DATA_WIDTH-1:0] rd_data_ff;
   logic [KW-1:0]                gs_ext;
   logic [KW-1:0]                k_eff;
   logic [KW-1:0]                new_fill;

   // clamp the group size into 1..MAX_GROUP
   always_comb begin
      gs_ext = KW'(group_size_ff);
      priority if (gs_ext == KW'(0)) begin
         k_eff = KW'(1);
      end else if (gs_ext > KW'(MAX_GROUP)) begin
         k_eff = KW'(MAX_GROUP);
      end else begin
         k_eff = gs_ext;
      end
   end

   assign new_fill       = KW'(fill_ff) + KW'(1);
   assign sts.group_full = (new_fill >= k_eff);
   assign sts.last_read  = (rem_ff == CW'(1));
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      fill_in = fill_ff;
      if (cmd.start) begin
         fill_in = CW'(0);
      end else if (cmd.write) begin
         fill_in = fill_ff + CW'(1);
      end
   end

   // drain walks down from the newest entry for a full group, up from zero otherwise
   always_comb begin
      rem_in  = rem_ff;
      addr_in = addr_ff;
      if (cmd.start) begin
         rem_in  = fill_ff + CW'(1);
         addr_in = sts.group_full ? fill_ff[AW-1:0] : AW'(0);
      end else if (cmd.rd) begin
         rem_in  = rem_ff - CW'(1);
         addr_in = rev_ff ? (addr_ff - AW'(1)) : (addr_ff + AW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= RIG_CSR_WIDTH'(1);
         fill_ff       <= CW'(0);
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            group_size_ff <= csr_group_size;
         end
         fill_ff <= fill_in;
         if (cmd.rd) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      addr_ff <= addr_in;
      if (cmd.start) begin
         rev_ff <= sts.group_full;
         eol_ff <= req_end_of_list;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[fill_ff[AW-1:0]] <= req_value;
      end
   end

   // registered read doubles as the output register
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_data_ff  <= mem[addr_ff];
         rsp_last_ff <= eol_ff && (rem_ff == CW'(1));
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rd_data_ff;
   assign rsp_out_last  = rsp_last_ff;

   `RIG_CHECK(a_fill_bound, 1'b1, fill_ff < CW'(MAX_GROUP), "fill count reached buffer depth")
   `RIG_CHECK(a_rd_no_overrun, cmd.rd, !rsp_valid_ff || rsp_ready, "read overwrote a held beat")
   `RIG_CHECK(a_write_not_drain, cmd.write, !cmd.rd, "write during drain")
   `RIG_CHECK_NEXT(a_drain_nonempty, cmd.start, rem_ff != CW'(0), "drain started with nothing")

endmodule

`default_nettype wire

@@ hw/rtl/reverse_in_groups_core.sv @@
// top level: reverses a value stream in groups of a programmable size
`default_nettype none

// Values enter one per beat on req_ and are stored in a single-port group buffer of
// MAX_GROUP entries. When the group fills (csr_group_size, clamped to 1..MAX_GROUP),
// the block stops taking input and reads the group out newest first, one beat per
// cycle while the output register is free, through the buffer's registered read
// port, which is also the output register. An end_of_list beat that leaves a partial
// group drains it in arrival order; the final beat of a list carries rsp_out_last.
// The next group may start filling while the last drained beat waits on rsp_.
// The buffer needs no clearing after reset. Write csr_group_size only while idle.
module reverse_in_groups_core #(
   parameter int MAX_GROUP  = rig_pkg::RIG_MAX_GROUP,
   parameter int DATA_WIDTH = rig_pkg::RIG_DATA_WIDTH
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire signed [DATA_WIDTH-1:0]      req_value,
   input  wire                              req_end_of_list,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic signed [DATA_WIDTH-1:0]     rsp_out_value,
   output logic                             rsp_out_last,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [rig_pkg::RIG_CSR_WIDTH-1:0] csr_group_size
);
   import rig_pkg::*;

   rig_cmd_type cmd;
   rig_sts_type sts;

   assign csr_ready = 1'b1;

   rig_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_end_of_list (req_end_of_list),
      .sts             (sts),
      .cmd             (cmd)
   );

   rig_datapath #(
      .MAX_GROUP  (MAX_GROUP),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_value       (req_value),
      .req_end_of_list (req_end_of_list),
      .csr_valid       (csr_valid),
      .csr_group_size  (csr_group_size),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_last    (rsp_out_last),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule

`default_nettype wire
